[sv/assert_macros.svh]
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked property, switched off while reset is held.
`define PCS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Checked property that also holds through reset.
`define PCS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

[sv/pcs_pkg.sv]
`timescale 1ns / 1ps

package pcs_pkg;

  localparam int QW   = 32;
  localparam int IDXW = 3;

  typedef logic signed [QW-1:0] q_t;
  typedef logic [QW-1:0]        gain_t;
  typedef logic [IDXW-1:0]      cfg_idx_t;

  typedef enum logic [IDXW-1:0] {
    REG_P_GAIN   = 3'd0,
    REG_I_GAIN   = 3'd1,
    REG_D_GAIN   = 3'd2,
    REG_REVERSE  = 3'd3,
    REG_OUT_MIN  = 3'd4,
    REG_OUT_MAX  = 3'd5
  } reg_idx_t;

  localparam q_t OUT_MAX_RST = 32'sd6553600;

  localparam logic signed [48:0] Q_MAX_W = 49'sd2147483647;
  localparam logic signed [48:0] Q_MIN_W = -49'sd2147483648;

  typedef struct packed {
    gain_t p_gain;
    gain_t i_gain;
    gain_t d_gain;
    logic  reverse;
    q_t    out_min;
    q_t    out_max;
  } cfg_t;

  typedef struct packed {
    q_t p_term;
    q_t i_term;
    q_t d_term;
  } prod_t;

  function automatic q_t sat_q(input logic signed [48:0] v);
    q_t res;
    if (v > Q_MAX_W) begin
      res = Q_MAX_W[QW-1:0];
    end else if (v < Q_MIN_W) begin
      res = Q_MIN_W[QW-1:0];
    end else begin
      res = v[QW-1:0];
    end
    return res;
  endfunction

  function automatic q_t clamp_lim(input logic signed [33:0] v, input q_t lo, input q_t hi);
    q_t res;
    if (v > 34'(hi)) begin
      res = hi;
    end else if (v < 34'(lo)) begin
      res = lo;
    end else begin
      res = v[QW-1:0];
    end
    return res;
  endfunction

  // Gain is unsigned Q16.16, negated for a reverse acting loop. The Q32.32
  // product is floored back to Q16.16 by the arithmetic shift.
  function automatic q_t gain_mul(input gain_t g, input logic rev, input q_t x);
    logic signed [32:0] gs;
    logic signed [64:0] prod;
    logic signed [64:0] shifted;
    gs      = rev ? -$signed({1'b0, g}) : $signed({1'b0, g});
    prod    = gs * x;
    shifted = prod >>> 16;
    return sat_q(shifted[48:0]);
  endfunction

endpackage

[sv/pcs_cfg.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcs_cfg (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_we,
  input  pcs_pkg::cfg_idx_t cfg_index,
  input  pcs_pkg::q_t       cfg_wdata,
  output pcs_pkg::cfg_t     cfg,
  output logic              lim_upd
);
  import pcs_pkg::*;

  cfg_t cfg_r, cfg_nxt;
  logic lim_upd_r, lim_upd_nxt;

  always_comb begin
    cfg_nxt     = cfg_r;
    lim_upd_nxt = 1'b0;
    if (cfg_we) begin
      case (cfg_index)
        REG_P_GAIN:  cfg_nxt.p_gain  = cfg_wdata;
        REG_I_GAIN:  cfg_nxt.i_gain  = cfg_wdata;
        REG_D_GAIN:  cfg_nxt.d_gain  = cfg_wdata;
        REG_REVERSE: cfg_nxt.reverse = cfg_wdata[0];
        REG_OUT_MIN: begin
          // A limit pair with min not below max is refused outright.
          if (cfg_wdata < cfg_r.out_max) begin
            cfg_nxt.out_min = cfg_wdata;
            lim_upd_nxt     = 1'b1;
          end
        end
        REG_OUT_MAX: begin
          if (cfg_r.out_min < cfg_wdata) begin
            cfg_nxt.out_max = cfg_wdata;
            lim_upd_nxt     = 1'b1;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.p_gain  <= '0;
      cfg_r.i_gain  <= '0;
      cfg_r.d_gain  <= '0;
      cfg_r.reverse <= 1'b0;
      cfg_r.out_min <= '0;
      cfg_r.out_max <= OUT_MAX_RST;
      lim_upd_r     <= 1'b0;
    end else begin
      cfg_r     <= cfg_nxt;
      lim_upd_r <= lim_upd_nxt;
    end
  end

  assign cfg     = cfg_r;
  assign lim_upd = lim_upd_r;

  `PCS_ASSERT(a_limits_ordered, cfg_r.out_min < cfg_r.out_max, "limits out of order")

endmodule

[sv/pcs_mul.sv]
`timescale 1ns / 1ps

module pcs_mul (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_load,
  input  logic           ab_move,
  input  pcs_pkg::q_t    in_meas,
  input  pcs_pkg::q_t    in_tgt,
  input  pcs_pkg::cfg_t  cfg,
  output pcs_pkg::prod_t prod
);
  import pcs_pkg::*;

  q_t    meas_r, tgt_r, prev_r;
  prod_t prod_r, prod_nxt;

  logic signed [32:0] err_w, dmeas_w;
  q_t                 err, dmeas;

  always_comb begin
    err_w          = 33'(tgt_r) - 33'(meas_r);
    dmeas_w        = 33'(meas_r) - 33'(prev_r);
    err            = sat_q(49'(err_w));
    dmeas          = sat_q(49'(dmeas_w));
    prod_nxt.p_term = gain_mul(cfg.p_gain, cfg.reverse, err);
    prod_nxt.i_term = gain_mul(cfg.i_gain, cfg.reverse, err);
    prod_nxt.d_term = gain_mul(cfg.d_gain, cfg.reverse, dmeas);
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      meas_r <= in_meas;
      tgt_r  <= in_tgt;
    end
    if (ab_move) begin
      prod_r <= prod_nxt;
    end
  end

  // The stored measurement follows the items in order as they leave this stage.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prev_r <= '0;
    end else if (ab_move) begin
      prev_r <= meas_r;
    end
  end

  assign prod = prod_r;

endmodule

[sv/pcs_acc.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

module pcs_acc (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           b_move,
  input  logic           lim_upd,
  input  pcs_pkg::cfg_t  cfg,
  input  pcs_pkg::prod_t prod,
  output pcs_pkg::q_t    drive
);
  import pcs_pkg::*;

  q_t integral_r, integral_nxt;
  q_t drive_r, drive_nxt;
  q_t integral_upd;

  always_comb begin
    integral_upd = clamp_lim(34'(integral_r) + 34'(prod.i_term), cfg.out_min, cfg.out_max);
    drive_nxt    = clamp_lim(34'(prod.p_term) + 34'(integral_upd) - 34'(prod.d_term),
                             cfg.out_min, cfg.out_max);
    if (b_move) begin
      integral_nxt = integral_upd;
    end else if (lim_upd) begin
      // New limits have just been taken: pull the integral inside them.
      integral_nxt = clamp_lim(34'(integral_r), cfg.out_min, cfg.out_max);
    end else begin
      integral_nxt = integral_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      integral_r <= '0;
    end else begin
      integral_r <= integral_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (b_move) begin
      drive_r <= drive_nxt;
    end
  end

  assign drive = drive_r;

  `PCS_ASSERT(a_integral_in_limits, !lim_upd |-> (integral_r >= cfg.out_min && integral_r <= cfg.out_max), "integral outside limits")

endmodule

[sv/pid_controller_step_top.sv]
`timescale 1ns / 1ps
`include "assert_macros.svh"

// Channel   Direction  Handshake                Payload
// in        input      in_valid / in_ready      in_measurement, in_target
// out       output     out_valid / out_ready    out_drive
// cfg       input      cfg_we (no wait)         cfg_index, cfg_wdata
//
// One item per clock is sustained while out_ready is high; an item's drive is
// put on out_drive after the input, product and result registers.
// The only loops are the integral add and clamp and the stored measurement.
// Reset (synchronous, rst_n low) clears the integral, the stored measurement,
// the config registers (out_max to OUT_MAX_RST) and all stage valid bits.
// A stalled result holds the pipeline; in_ready drops only when all three
// stages are full and out_ready is low.
module pid_controller_step_top (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  pcs_pkg::q_t       in_measurement,
  input  pcs_pkg::q_t       in_target,
  output logic              out_valid,
  input  logic              out_ready,
  output pcs_pkg::q_t       out_drive,
  input  logic              cfg_we,
  input  pcs_pkg::cfg_idx_t cfg_index,
  input  pcs_pkg::q_t       cfg_wdata
);
  import pcs_pkg::*;

  cfg_t  cfg;
  logic  lim_upd;
  prod_t prod;

  logic a_v_r, a_v_nxt;
  logic b_v_r, b_v_nxt;
  logic o_v_r, o_v_nxt;
  logic o_rdy, b_rdy, a_rdy;
  logic in_load, ab_move, b_move;

  assign o_rdy   = !o_v_r || out_ready;
  assign b_rdy   = !b_v_r || o_rdy;
  assign a_rdy   = !a_v_r || b_rdy;
  assign in_load = in_valid && a_rdy;
  assign ab_move = a_v_r && b_rdy;
  assign b_move  = b_v_r && o_rdy;

  always_comb begin
    a_v_nxt = a_rdy ? in_valid : a_v_r;
    b_v_nxt = b_rdy ? a_v_r : b_v_r;
    o_v_nxt = o_rdy ? b_v_r : o_v_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_v_r <= 1'b0;
      b_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      a_v_r <= a_v_nxt;
      b_v_r <= b_v_nxt;
      o_v_r <= o_v_nxt;
    end
  end

  pcs_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg),
    .lim_upd   (lim_upd)
  );

  pcs_mul u_mul (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_load (in_load),
    .ab_move (ab_move),
    .in_meas (in_measurement),
    .in_tgt  (in_target),
    .cfg     (cfg),
    .prod    (prod)
  );

  pcs_acc u_acc (
    .clk     (clk),
    .rst_n   (rst_n),
    .b_move  (b_move),
    .lim_upd (lim_upd),
    .cfg     (cfg),
    .prod    (prod),
    .drive   (out_drive)
  );

  assign in_ready  = a_rdy;
  assign out_valid = o_v_r;

  `PCS_ASSERT(a_backpressure_source, !in_ready |-> (out_valid && !out_ready),
              "input stalled without output stall")
  `PCS_ASSERT(a_result_from_stage, $rose(out_valid) |-> $past(b_v_r),
              "result transaction without a product")

endmodule
